// ===== rtl/core/rap_pkg.sv =====
// shared types and constants of the resp array request parser
package rap_pkg;

  // default width of the argument counter
  localparam int DEF_ARG_COUNT_BITS = 16;

  // result queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // width of the fixed result fields
  localparam int IDX_W = 16;

  // protocol bytes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // count limits of a 32-bit signed value
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // parser phases
  typedef enum logic [3:0] {
    PH_FIRST     = 4'd0,
    PH_NOTARR    = 4'd1,
    PH_CNT_WS    = 4'd2,
    PH_CNT_NUM   = 4'd3,
    PH_CNT_TAIL  = 4'd4,
    PH_SKIP_HDR  = 4'd5,
    PH_HDR       = 4'd6,
    PH_HDR_BULK  = 4'd7,
    PH_SKIP_DATA = 4'd8,
    PH_DATA      = 4'd9,
    PH_DRAIN     = 4'd10
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  // request status on done
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTARR   = 2'd1,
    ST_NODIGITS = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // results caused by one byte, in delivery order: data, end, done
  typedef struct packed {
    logic             has_data;
    logic             has_end;
    logic             has_done;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    status_t          status;
    logic [IDX_W-1:0] count;
  } rec_t;

endpackage

// ===== rtl/core/rap_front.sv =====
// byte parser: classifies each request byte and records the results it causes
module rap_front #(
  parameter int ARG_COUNT_BITS = rap_pkg::DEF_ARG_COUNT_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          in_ready,
  output logic          rec_valid,
  output rap_pkg::rec_t rec,
  input  logic          rec_ready
);

  localparam int ARG_W = (ARG_COUNT_BITS >= rap_pkg::IDX_W) ? rap_pkg::IDX_W : ARG_COUNT_BITS;

  rap_pkg::phase_t phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic             digits_r, digits_nxt;
  logic [31:0]      elem_r, elem_nxt;
  logic [ARG_W-1:0] args_r, args_nxt;
  logic             lhb_r, lhb_nxt;

  logic accept;
  logic is_cr, is_digit, is_ws, is_sign, is_minus, is_star, is_dollar;
  logic upd_en, in_ws_phase;
  logic [35:0] mag_wide;
  logic [31:0] mag_digit, mag_upd;
  logic        digits_upd, neg_upd, range_bad, eval_fin;
  rap_pkg::status_t eval_st, fin_st;
  logic [31:0]      elem_inc;
  logic [ARG_W-1:0] args_inc;
  logic             reached;
  logic do_data, do_end, do_fin, bad_phase, clear;

  assign in_ready = rec_ready;
  assign accept   = in_valid && rec_ready;

  // byte classes
  assign is_cr     = (in_byte == rap_pkg::CH_CR);
  assign is_star   = (in_byte == rap_pkg::CH_STAR);
  assign is_dollar = (in_byte == rap_pkg::CH_DOLLAR);
  assign is_digit  = (in_byte >= rap_pkg::CH_ZERO) && (in_byte <= rap_pkg::CH_NINE);
  assign is_ws     = (in_byte == rap_pkg::CH_SPACE) ||
                     ((in_byte >= rap_pkg::CH_TAB) && (in_byte <= rap_pkg::CH_CR));
  assign is_minus  = (in_byte == rap_pkg::CH_MINUS);
  assign is_sign   = (in_byte == rap_pkg::CH_PLUS) || is_minus;

  // count accumulation, saturating at all ones
  assign mag_wide  = {mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {32'd0, in_byte[3:0] - 4'd0};
  assign mag_digit = (mag_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : mag_wide[31:0];

  assign in_ws_phase = (phase_r == rap_pkg::PH_CNT_WS);
  assign upd_en      = (in_ws_phase || (phase_r == rap_pkg::PH_CNT_NUM)) && !is_cr;
  assign mag_upd     = (upd_en && is_digit) ? mag_digit : mag_r;
  assign digits_upd  = digits_r || (upd_en && is_digit);
  assign neg_upd     = (upd_en && in_ws_phase && is_sign) ? is_minus : neg_r;

  // count evaluation on the values after this byte
  assign range_bad = neg_upd ? (mag_upd > rap_pkg::NEG_LIMIT) : (mag_upd > rap_pkg::POS_LIMIT);
  assign eval_fin  = !digits_upd || range_bad || neg_upd || (mag_upd == 32'd0) || in_last;
  assign eval_st   = !digits_upd ? rap_pkg::ST_NODIGITS :
                     (range_bad ? rap_pkg::ST_RANGE : rap_pkg::ST_OK);

  // saturating counters
  assign elem_inc = (elem_r == 32'hFFFF_FFFF) ? elem_r : elem_r + 32'd1;
  assign args_inc = (args_r == {ARG_W{1'b1}}) ? args_r : args_r + ARG_W'(1);
  assign reached  = (elem_inc >= mag_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      rap_pkg::PH_FIRST: begin
        if (is_star) begin
          phase_nxt = rap_pkg::PH_CNT_WS;
        end else if (!is_cr) begin
          phase_nxt = rap_pkg::PH_NOTARR;
        end
      end
      rap_pkg::PH_NOTARR: begin
        phase_nxt = rap_pkg::PH_NOTARR;
      end
      rap_pkg::PH_CNT_WS, rap_pkg::PH_CNT_NUM: begin
        if (is_cr) begin
          phase_nxt = rap_pkg::PH_SKIP_HDR;
        end else if (is_digit) begin
          phase_nxt = rap_pkg::PH_CNT_NUM;
        end else if (in_ws_phase && is_ws) begin
          phase_nxt = rap_pkg::PH_CNT_WS;
        end else if (in_ws_phase && is_sign) begin
          phase_nxt = rap_pkg::PH_CNT_NUM;
        end else begin
          phase_nxt = rap_pkg::PH_CNT_TAIL;
        end
      end
      rap_pkg::PH_CNT_TAIL: begin
        if (is_cr) begin
          phase_nxt = rap_pkg::PH_SKIP_HDR;
        end
      end
      rap_pkg::PH_SKIP_HDR: begin
        phase_nxt = rap_pkg::PH_HDR;
      end
      rap_pkg::PH_HDR: begin
        if (is_cr) begin
          phase_nxt = rap_pkg::PH_SKIP_HDR;
        end else if (!lhb_r && is_dollar) begin
          phase_nxt = rap_pkg::PH_HDR_BULK;
        end
      end
      rap_pkg::PH_HDR_BULK: begin
        if (is_cr) begin
          phase_nxt = rap_pkg::PH_SKIP_DATA;
        end
      end
      rap_pkg::PH_SKIP_DATA: begin
        phase_nxt = rap_pkg::PH_DATA;
      end
      rap_pkg::PH_DATA: begin
        if (is_cr) begin
          phase_nxt = rap_pkg::PH_SKIP_HDR;
        end
      end
      rap_pkg::PH_DRAIN: begin
        phase_nxt = rap_pkg::PH_DRAIN;
      end
      default: begin
        phase_nxt = rap_pkg::PH_FIRST;
      end
    endcase
    if (do_fin) begin
      phase_nxt = in_last ? rap_pkg::PH_FIRST : rap_pkg::PH_DRAIN;
    end else if (clear) begin
      phase_nxt = rap_pkg::PH_FIRST;
    end
  end

  // results and counter updates
  always_comb begin
    neg_nxt    = neg_upd;
    mag_nxt    = mag_upd;
    digits_nxt = digits_upd;
    elem_nxt   = elem_r;
    args_nxt   = args_r;
    lhb_nxt    = lhb_r;
    do_data    = 1'b0;
    do_end     = 1'b0;
    do_fin     = 1'b0;
    fin_st     = rap_pkg::ST_OK;
    bad_phase  = 1'b0;
    case (phase_r)
      rap_pkg::PH_FIRST: begin
        if (is_cr) begin
          do_fin = 1'b1;
          fin_st = rap_pkg::ST_NOTARR;
        end else if (is_star) begin
          do_fin = in_last;
          fin_st = eval_st;
        end else begin
          do_fin = in_last;
          fin_st = rap_pkg::ST_NOTARR;
        end
      end
      rap_pkg::PH_NOTARR: begin
        do_fin = is_cr || in_last;
        fin_st = rap_pkg::ST_NOTARR;
      end
      rap_pkg::PH_CNT_WS, rap_pkg::PH_CNT_NUM, rap_pkg::PH_CNT_TAIL: begin
        do_fin = (is_cr || in_last) && eval_fin;
        fin_st = eval_st;
      end
      rap_pkg::PH_SKIP_HDR: begin
        lhb_nxt = 1'b0;
        do_fin  = in_last;
      end
      rap_pkg::PH_HDR: begin
        if (is_cr) begin
          if (!lhb_r) begin
            do_fin = 1'b1;
          end else begin
            elem_nxt = elem_inc;
            lhb_nxt  = 1'b0;
            do_fin   = reached || in_last;
          end
        end else if (!lhb_r && is_dollar) begin
          lhb_nxt = 1'b1;
          do_end  = in_last;
          do_fin  = in_last;
        end else begin
          lhb_nxt = 1'b1;
          do_fin  = in_last;
        end
      end
      rap_pkg::PH_HDR_BULK, rap_pkg::PH_SKIP_DATA: begin
        do_end = in_last;
        do_fin = in_last;
      end
      rap_pkg::PH_DATA: begin
        if (is_cr) begin
          do_end = 1'b1;
          do_fin = reached || in_last;
        end else begin
          do_data = 1'b1;
          do_end  = in_last;
          do_fin  = in_last;
        end
      end
      rap_pkg::PH_DRAIN: begin
        do_fin = 1'b0;
      end
      default: begin
        bad_phase = 1'b1;
      end
    endcase
    if (do_end) begin
      args_nxt = args_inc;
      elem_nxt = elem_inc;
    end
    if (clear) begin
      neg_nxt    = 1'b0;
      mag_nxt    = 32'd0;
      digits_nxt = 1'b0;
      elem_nxt   = 32'd0;
      args_nxt   = '0;
      lhb_nxt    = 1'b0;
    end
  end

  // a request ends on its final byte once done is out, or on a stray phase
  assign clear = (in_last && (do_fin || (phase_r == rap_pkg::PH_DRAIN))) || bad_phase;

  // record of this byte's results
  always_comb begin
    rec.has_data = do_data;
    rec.has_end  = do_end;
    rec.has_done = do_fin;
    rec.data     = in_byte;
    rec.idx      = rap_pkg::IDX_W'(args_r);
    rec.status   = fin_st;
    rec.count    = do_end ? rap_pkg::IDX_W'(args_inc) : rap_pkg::IDX_W'(args_r);
  end

  assign rec_valid = accept && (do_data || do_end || do_fin);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rap_pkg::PH_FIRST;
      neg_r    <= 1'b0;
      mag_r    <= 32'd0;
      digits_r <= 1'b0;
      elem_r   <= 32'd0;
      args_r   <= '0;
      lhb_r    <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      digits_r <= digits_nxt;
      elem_r   <= elem_nxt;
      args_r   <= args_nxt;
      lhb_r    <= lhb_nxt;
    end
  end

endmodule

// ===== rtl/core/rap_queue.sv =====
// short queue of result records between the parser and the result sequencer
module rap_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  rap_pkg::rec_t push_rec,
  output logic          push_ready,
  output logic          pop_valid,
  output rap_pkg::rec_t pop_rec,
  input  logic          pop_en
);

  rap_pkg::rec_t                 mem [rap_pkg::QUEUE_DEPTH];
  logic [rap_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [rap_pkg::QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != (rap_pkg::QUEUE_AW + 1)'(rap_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_rec    = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/rap_back.sv =====
// result sequencer: expands each record into one to three result transfers
module rap_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  input  rap_pkg::rec_t               pop_rec,
  output logic                        pop_en,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rap_pkg::kind_t              res_kind,
  output logic [7:0]                  res_byte,
  output logic [rap_pkg::IDX_W-1:0]   res_idx,
  output rap_pkg::status_t            res_status,
  output logic [rap_pkg::IDX_W-1:0]   res_count,
  output logic                        res_last
);

  // pending bits: data in bit 0, end in bit 1, done in bit 2
  rap_pkg::rec_t cur_r, cur_nxt;
  logic [2:0]    pend_r, pend_nxt;
  logic          take, single, load;

  assign res_valid = (pend_r != 3'b000);
  assign single    = ((pend_r & (pend_r - 3'd1)) == 3'b000);
  assign take      = res_valid && res_ready;
  assign load      = pop_valid && (!res_valid || (take && single));
  assign pop_en    = load;
  assign res_last  = single;

  // current result fields
  always_comb begin
    if (pend_r[0]) begin
      res_kind = rap_pkg::KIND_DATA;
    end else if (pend_r[1]) begin
      res_kind = rap_pkg::KIND_END;
    end else begin
      res_kind = rap_pkg::KIND_DONE;
    end
    res_byte   = pend_r[0] ? cur_r.data : 8'd0;
    res_idx    = (pend_r[0] || pend_r[1]) ? cur_r.idx : '0;
    res_status = (res_kind == rap_pkg::KIND_DONE) ? cur_r.status : rap_pkg::ST_OK;
    res_count  = (res_kind == rap_pkg::KIND_DONE) ? cur_r.count : '0;
  end

  // next record and pending set
  always_comb begin
    cur_nxt  = cur_r;
    pend_nxt = pend_r;
    if (load) begin
      cur_nxt  = pop_rec;
      pend_nxt = {pop_rec.has_done, pop_rec.has_end, pop_rec.has_data};
    end else if (take) begin
      pend_nxt = pend_r & (pend_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// ===== rtl/core/resp_array_request_parser.sv =====
// top level of the resp array request parser
//
// Request buffer bytes enter on the in_ channel, one byte per transfer, with
// in_tlast high on the final byte of a buffer. Results leave on the out_
// channel: argument data bytes, argument ends and one done per request,
// told apart by out_tuser; out_tlast marks the last result of an input byte.
// The parser takes one byte per cycle while the queue has room and writes
// the results of each byte as one record into a four-entry queue; the
// sequencer then sends one result per cycle while the receiver is ready.
// Each record is stored in the queue before the sequencer loads it. Bytes
// that cause one result or none go through at one per cycle while the
// receiver is ready; a byte that ends an argument and a request causes up
// to three results, which the queue absorbs while later bytes keep arriving.
// When the receiver stalls, the current result holds and the queue fills;
// once it is full, in_tready drops until a record is taken from it.
// Reset empties the queue and returns the parser to the first line of a
// request with all counts cleared.
module resp_array_request_parser #(
  parameter int ARG_COUNT_BITS = rap_pkg::DEF_ARG_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] byte_out, [23:8] arg_index, [25:24] status,
                                  // [41:26] arg_count, [47:42] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // run_end
);

  logic          rec_valid, rec_ready;
  rap_pkg::rec_t rec;
  logic          pop_valid, pop_en;
  rap_pkg::rec_t pop_rec;

  rap_pkg::kind_t                res_kind;
  logic [7:0]                    res_byte;
  logic [rap_pkg::IDX_W-1:0]     res_idx;
  rap_pkg::status_t              res_status;
  logic [rap_pkg::IDX_W-1:0]     res_count;

  // byte parser
  rap_front #(
    .ARG_COUNT_BITS(ARG_COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .rec_valid(rec_valid),
    .rec      (rec),
    .rec_ready(rec_ready)
  );

  // record queue
  rap_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(rec_valid),
    .push_rec  (rec),
    .push_ready(rec_ready),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop_en    (pop_en)
  );

  // result sequencer
  rap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop_en    (pop_en),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (res_kind),
    .res_byte  (res_byte),
    .res_idx   (res_idx),
    .res_status(res_status),
    .res_count (res_count),
    .res_last  (out_tlast)
  );

  // output packing
  assign out_tdata = {6'd0, res_count, res_status, res_idx, res_byte};
  assign out_tuser = res_kind;

endmodule
